### rtl/tlbri_pkg.sv
// ----------------------------------------------------------------------------
// tlbri_pkg: shared types and constants for the TLB refill/invalidate block
// Entry geometry, field widths, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
package tlbri_pkg;

    localparam int TLB_ENTRIES      = 64;
    localparam int PAGE_NUMBER_BITS = 20;
    localparam int IDX_W            = $clog2(TLB_ENTRIES);
    localparam int CNT_W            = $clog2(TLB_ENTRIES + 1);
    localparam int REG_W            = 20;
    localparam int SLOT_W           = 6;
    localparam int CLEARED_W        = 7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    // configuration register indexes
    localparam logic [0:0] REG_TEXT_FIRST = 1'b0;
    localparam logic [0:0] REG_TEXT_COUNT = 1'b1;

    // item opcodes
    localparam logic OP_REFILL     = 1'b0;
    localparam logic OP_INVALIDATE = 1'b1;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_VICT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    typedef struct packed {
        logic [PAGE_NUMBER_BITS-1:0] page;
        logic [PAGE_NUMBER_BITS-1:0] frame;
    } entry_t;

    typedef struct packed {
        logic in_text;
        logic frame_eq;
    } cmp_res_t;

endpackage

### rtl/tlbri_cmp.sv
// ----------------------------------------------------------------------------
// tlbri_cmp: shared page compare unit
// Range test of one page against the text segment and frame equality test.
// ----------------------------------------------------------------------------
module tlbri_cmp (
    input  logic [tlbri_pkg::PAGE_NUMBER_BITS-1:0] page,
    input  logic [tlbri_pkg::PAGE_NUMBER_BITS-1:0] frame,
    input  logic [tlbri_pkg::PAGE_NUMBER_BITS-1:0] frame_key,
    input  logic [tlbri_pkg::REG_W-1:0]            text_first,
    input  logic [tlbri_pkg::REG_W-1:0]            text_count,
    output tlbri_pkg::cmp_res_t                    res
);
    import tlbri_pkg::*;

    localparam int CW = (PAGE_NUMBER_BITS > REG_W) ? PAGE_NUMBER_BITS + 1 : REG_W + 1;

    logic [CW-1:0] top_w;
    logic [CW-1:0] first_w;
    logic [CW-1:0] page_w;

    // top is one past the last text page, kept a bit wider so it never wraps
    assign first_w = CW'(text_first);
    assign top_w   = CW'(text_first) + CW'(text_count);
    assign page_w  = CW'(page);

    assign res.in_text  = (page_w >= first_w) && (page_w < top_w);
    assign res.frame_eq = (frame == frame_key);

endmodule

### rtl/tlb_refill_and_invalidate.sv
// ----------------------------------------------------------------------------
// tlb_refill_and_invalidate: TLB refill and frame invalidate, round-robin replacement
// Walks the TLB one entry per cycle through a single compare unit.
// ----------------------------------------------------------------------------
// Operation: a free-slot refill ends the walk at the first invalid entry; an
//   invalidate walks every entry; a full-TLB refill walks all, then writes the victim.
// Items: one item at a time, none taken until the last result leaves the hold state;
//   the walk reads one entry per cycle from the page/frame memory (one write, one read port).
// Reset (aresetn low, synchronous): all entries invalid and clean, victim pointer
//   and text registers zero, no result pending. No clearing pass is needed.
module tlb_refill_and_invalidate (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [19:0] virtual_page, [39:20] frame_page
    input  logic [0:0]  s_tuser,   // [0] op
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [5:0] slot, [6] was_replacement,
                                   // [7] written_read_only, [14:8] cleared_count,
                                   // [15] zero
);
    import tlbri_pkg::*;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [1:0]                  state_reg,   state_next;
    logic [REG_W-1:0]            first_reg,   first_next;
    logic [REG_W-1:0]            count_reg,   count_next;
    logic [TLB_ENTRIES-1:0]      valid_reg,   valid_next;
    logic [TLB_ENTRIES-1:0]      dirty_reg,   dirty_next;
    logic [IDX_W-1:0]            victim_reg,  victim_next;

    logic                        op_reg,      op_next;
    logic [PAGE_NUMBER_BITS-1:0] vpage_reg,   vpage_next;
    logic [PAGE_NUMBER_BITS-1:0] frame_reg,   frame_next;

    // walk pipeline: read index, then evaluate index in the following cycle
    logic [IDX_W-1:0]            rd_idx_reg,  rd_idx_next;
    logic                        rd_more_reg, rd_more_next;
    logic [IDX_W-1:0]            ev_idx_reg,  ev_idx_next;
    logic                        ev_vld_reg,  ev_vld_next;
    logic [CNT_W-1:0]            cnt_reg,     cnt_next;

    // finished result waiting for the output register
    logic [IDX_W-1:0]            res_slot_reg, res_slot_next;
    logic                        res_rep_reg,  res_rep_next;
    logic                        res_ro_reg,   res_ro_next;

    logic                        m_vld_reg,   m_vld_next;
    logic [15:0]                 m_data_reg,  m_data_next;

    // page/frame store; contents of invalid entries never reach a result
    entry_t                      mem [TLB_ENTRIES];
    entry_t                      rd_data_reg;
    logic                        rd_en;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    entry_t                      mem_wdata;

    // shared compare unit
    logic [PAGE_NUMBER_BITS-1:0] cmp_page;
    cmp_res_t                    cmp_res;

    logic                        s_acc;
    logic                        out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_vld_reg || m_tready;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    assign rd_en     = (state_reg == ST_SCAN) && rd_more_reg;
    assign mem_wdata = '{page: vpage_reg, frame: frame_reg};

    // the victim write tests the incoming page, the walk tests the stored one
    assign cmp_page = (state_reg == ST_VICT) ? vpage_reg : rd_data_reg.page;

    tlbri_cmp u_cmp (
        .page       (cmp_page),
        .frame      (rd_data_reg.frame),
        .frame_key  (frame_reg),
        .text_first (first_reg),
        .text_count (count_reg),
        .res        (cmp_res)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        first_next    = first_reg;
        count_next    = count_reg;
        valid_next    = valid_reg;
        dirty_next    = dirty_reg;
        victim_next   = victim_reg;
        op_next       = op_reg;
        vpage_next    = vpage_reg;
        frame_next    = frame_reg;
        rd_idx_next   = rd_idx_reg;
        rd_more_next  = rd_more_reg;
        ev_idx_next   = rd_idx_reg;
        ev_vld_next   = rd_en;
        cnt_next      = cnt_reg;
        res_slot_next = res_slot_reg;
        res_rep_next  = res_rep_reg;
        res_ro_next   = res_ro_reg;
        m_vld_next    = m_vld_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = ev_idx_reg;

        if (m_vld_reg && m_tready) begin
            m_vld_next = 1'b0;
        end

        if (cfg_wen) begin
            case (cfg_index)
                REG_TEXT_FIRST: first_next = cfg_wdata;
                REG_TEXT_COUNT: count_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    op_next       = s_tuser[0];
                    vpage_next    = s_tdata[PAGE_NUMBER_BITS-1:0];
                    frame_next    = s_tdata[20 +: PAGE_NUMBER_BITS];
                    rd_idx_next   = '0;
                    rd_more_next  = 1'b1;
                    cnt_next      = '0;
                    res_slot_next = '0;
                    res_rep_next  = 1'b0;
                    res_ro_next   = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    rd_more_next = (rd_idx_reg != LAST_IDX);
                end
                if (ev_vld_reg) begin
                    if (op_reg == OP_INVALIDATE) begin
                        if (cmp_res.frame_eq) begin
                            if (valid_reg[ev_idx_reg]) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                            valid_next[ev_idx_reg] = 1'b0;
                            dirty_next[ev_idx_reg] = 1'b0;
                        end
                        if (ev_idx_reg == LAST_IDX) begin
                            state_next = ST_HOLD;
                        end
                    end else if (valid_reg[ev_idx_reg]) begin
                        // valid text entries lose write permission
                        if (cmp_res.in_text) begin
                            dirty_next[ev_idx_reg] = 1'b0;
                        end
                        if (ev_idx_reg == LAST_IDX) begin
                            state_next = ST_VICT;
                        end
                    end else begin
                        // first free entry: take it and stop the walk
                        mem_we                 = 1'b1;
                        valid_next[ev_idx_reg] = 1'b1;
                        dirty_next[ev_idx_reg] = 1'b1;
                        res_slot_next          = ev_idx_reg;
                        rd_more_next           = 1'b0;
                        state_next             = ST_HOLD;
                    end
                end
            end
            ST_VICT: begin
                mem_we                 = 1'b1;
                mem_waddr              = victim_reg;
                valid_next[victim_reg] = 1'b1;
                dirty_next[victim_reg] = !cmp_res.in_text;
                res_slot_next          = victim_reg;
                res_rep_next           = 1'b1;
                res_ro_next            = cmp_res.in_text;
                victim_next            = (victim_reg == LAST_IDX) ? '0 : victim_reg + 1'b1;
                state_next             = ST_HOLD;
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_vld_next  = 1'b1;
                    m_data_next = {1'b0, CLEARED_W'(cnt_reg), res_ro_reg, res_rep_reg,
                                   SLOT_W'(res_slot_reg)};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_reg   <= '0;
            count_reg   <= '0;
            valid_reg   <= '0;
            dirty_reg   <= '0;
            victim_reg  <= '0;
            rd_more_reg <= 1'b0;
            ev_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            count_reg   <= count_next;
            valid_reg   <= valid_next;
            dirty_reg   <= dirty_next;
            victim_reg  <= victim_next;
            rd_more_reg <= rd_more_next;
            ev_vld_reg  <= ev_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        vpage_reg    <= vpage_next;
        frame_reg    <= frame_next;
        rd_idx_reg   <= rd_idx_next;
        ev_idx_reg   <= ev_idx_next;
        cnt_reg      <= cnt_next;
        res_slot_reg <= res_slot_next;
        res_rep_reg  <= res_rep_next;
        res_ro_reg   <= res_ro_next;
        m_data_reg   <= m_data_next;
    end

    // page/frame memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

`ifndef SYNTHESIS
    // a new result only comes out of the hold state
    a_result_from_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_vld_reg) |-> $past(state_reg) == ST_HOLD)
        else $error("result loaded outside hold state");

    // no walk evaluation is left over once the block is idle
    a_idle_no_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ev_vld_reg)
        else $error("walk still evaluating while idle");

    // a refill into a free entry leaves that entry valid
    a_free_fill_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && ev_vld_reg && op_reg == OP_REFILL &&
         !valid_reg[ev_idx_reg]) |=> valid_reg[$past(ev_idx_reg)])
        else $error("free entry not marked valid after refill");

    // a result with a nonzero cleared count (an invalidate) reports no slot and no replacement
    a_inval_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && m_data_reg[14:8] != '0) |-> (m_data_reg[7:0] == '0))
        else $error("invalidate result carries refill fields");
`endif

endmodule
